### design/sem_pkg.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared types and constants for the gradient magnitude block.
// ----------------------------------------------------------------------------
`default_nettype none

package sem_pkg;

  localparam int DATA_W     = 8;
  localparam int GRAD_W     = 11;
  localparam int SUM_W      = 21;
  localparam int MAX_HEIGHT = 4096;
  localparam int HCFG_W     = 13;
  localparam int WCFG_W     = 11;
  localparam int CCFG_W     = 3;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAN   = 2'd2;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  localparam logic [SUM_W-1:0] SAT_LIMIT = 21'd65025;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_WAIT   = 8'b0000_0010,
    S_DECIDE = 8'b0000_0100,
    S_READ   = 8'b0000_1000,
    S_ACC    = 8'b0001_0000,
    S_SQ     = 8'b0010_0000,
    S_MAG    = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mag_stat_t;

endpackage

`default_nettype wire

### design/sobel_edge_magnitude_top.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude, top level
// 3x3 Sobel gradient magnitude over an interleaved raster sample stream.
// ----------------------------------------------------------------------------
// Input words carry one 8-bit channel sample in in_tdata, with in_tuser low,
// in raster order and channels interleaved. After the frame's last sample,
// words with in_tuser high drain the results still owed. Each result word
// carries the saturated magnitude in out_tdata; out_tlast marks the frame's
// final result. Results lag the input by one row plus one pixel.
// An accepted word that yields no result passes the wait and decide states
// only. A word that yields a result takes 9 line buffer reads (one read port),
// then a squaring step and an 8-step root, which stops early when the sum of
// squares saturates; the next word can be taken in the cycle after the result
// word leaves. The rate is set by the single read port of the line buffer and
// the bit-serial root.
// A stalled receiver holds the result in the output register and the block
// takes no input meanwhile. Reset clears the counters and restores the
// register defaults (1024 x 1024, one channel); a register write starts a
// new frame. Line buffer contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_edge_magnitude_top #(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_CHANNELS = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [sem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sem_pkg::HCFG_W-1:0]    cfg_wdata,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [sem_pkg::DATA_W-1:0]    in_tdata,   // [7:0] sample
  input  wire logic                          in_tuser,   // [0] func
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [sem_pkg::DATA_W-1:0]    out_tdata,  // [7:0] magnitude
  output logic                               out_tlast
);
  import sem_pkg::*;

  localparam int ROW_SPAN = MAX_WIDTH * MAX_CHANNELS;
  localparam int IDX_W    = $clog2(ROW_SPAN);
  localparam int ADDR_W   = IDX_W + 2;
  localparam int X_W      = $clog2(MAX_WIDTH + 1);
  localparam int CH_W     = $clog2(MAX_CHANNELS + 1);
  localparam int Y_W      = $clog2(MAX_HEIGHT);
  localparam int WH_W     = X_W + HCFG_W;
  localparam int TOT_W    = $clog2(MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS + 1);

  state_t state_r, state_nxt;

  logic [WCFG_W-1:0] img_width_r;
  logic [HCFG_W-1:0] img_height_r;
  logic [CCFG_W-1:0] chan_count_r;

  logic [X_W-1:0]    w_eff;
  logic [HCFG_W-1:0] h_eff;
  logic [CH_W-1:0]   c_eff;
  logic [IDX_W:0]    rowlen_r;
  logic [TOT_W-1:0]  lag_r, total_r;
  logic [WH_W-1:0]   wh_r;

  logic              func_r;
  logic [DATA_W-1:0] sample_r;

  logic [TOT_W-1:0]  i_cnt_r, o_cnt_r;
  logic [IDX_W-1:0]  i_idx_r, o_idx_r;
  logic [1:0]        i_row_r;
  logic [CH_W-1:0]   o_c_r;
  logic [X_W-1:0]    o_x_r;
  logic [Y_W-1:0]    o_y_r;
  logic              last_r;

  logic [1:0]        tx_r, ty_r, ptx_r, pty_r;
  logic              rd_pend_r;
  logic signed [GRAD_W-1:0] gx_r, gy_r;

  logic              wr_en, rd_en, emit;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic [Y_W-1:0]    row_sel;
  logic [IDX_W-1:0]  col_sel;
  logic              pix_ok;

  logic [DATA_W-1:0] out_data_r, mag;
  logic              out_last_r;
  mag_stat_t         mag_stat;

  logic signed [GRAD_W-1:0] v1, v2, wx, wy;

  // Effective register values, saturated into range.
  always_comb begin
    if (img_width_r == '0) begin
      w_eff = X_W'(1);
    end else if (32'(img_width_r) > MAX_WIDTH) begin
      w_eff = X_W'(MAX_WIDTH);
    end else begin
      w_eff = X_W'(img_width_r);
    end
    if (img_height_r == '0) begin
      h_eff = HCFG_W'(1);
    end else if (32'(img_height_r) > MAX_HEIGHT) begin
      h_eff = HCFG_W'(MAX_HEIGHT);
    end else begin
      h_eff = img_height_r;
    end
    if (chan_count_r == '0) begin
      c_eff = CH_W'(1);
    end else if (32'(chan_count_r) > MAX_CHANNELS) begin
      c_eff = CH_W'(MAX_CHANNELS);
    end else begin
      c_eff = CH_W'(chan_count_r);
    end
  end

  always_ff @(posedge clk) begin
    rowlen_r <= (IDX_W+1)'(w_eff) * (IDX_W+1)'(c_eff);
    lag_r    <= (TOT_W'(w_eff) + TOT_W'(1)) * TOT_W'(c_eff);
    wh_r     <= WH_W'(w_eff) * WH_W'(h_eff);
    total_r  <= TOT_W'(wh_r) * TOT_W'(c_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_width_r  <= WCFG_W'(1024);
      img_height_r <= HCFG_W'(1024);
      chan_count_r <= CCFG_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_WIDTH:  img_width_r  <= cfg_wdata[WCFG_W-1:0];
        CFG_HEIGHT: img_height_r <= cfg_wdata;
        CFG_CHAN:   chan_count_r <= cfg_wdata[CCFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Decision for the word under work.
  always_comb begin
    pix_ok = (func_r == FUNC_PIXEL) && (i_cnt_r < total_r);
    wr_en  = (state_r == S_DECIDE) && pix_ok;
    wr_addr = {i_row_r, i_idx_r};
    if (func_r == FUNC_PIXEL) begin
      emit = pix_ok && (i_cnt_r >= lag_r);
    end else begin
      emit = (i_cnt_r == total_r) && (o_cnt_r < total_r);
    end
  end

  // Neighbor address with edge clamping.
  always_comb begin
    case (ty_r)
      2'd0:    row_sel = (o_y_r == '0) ? o_y_r : o_y_r - 1'b1;
      2'd2:    row_sel = ((HCFG_W'(o_y_r) + 1'b1) == h_eff) ? o_y_r : o_y_r + 1'b1;
      default: row_sel = o_y_r;
    endcase
    case (tx_r)
      2'd0:    col_sel = (o_x_r == '0) ? o_idx_r : o_idx_r - IDX_W'(c_eff);
      2'd2:    col_sel = ((o_x_r + 1'b1) == w_eff) ? o_idx_r : o_idx_r + IDX_W'(c_eff);
      default: col_sel = o_idx_r;
    endcase
    rd_en   = (state_r == S_READ);
    rd_addr = {row_sel[1:0], col_sel};
  end

  // Kernel weights: the center row (for X) or column (for Y) counts double.
  always_comb begin
    v1 = $signed({{(GRAD_W-DATA_W){1'b0}}, rd_data});
    v2 = v1 <<< 1;
    wx = (pty_r == 2'd1) ? v2 : v1;
    wy = (ptx_r == 2'd1) ? v2 : v1;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_WAIT;
      S_WAIT:   state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = emit ? S_READ : S_IDLE;
      S_READ:   if (ty_r == 2'd2 && tx_r == 2'd2) state_nxt = S_ACC;
      S_ACC:    state_nxt = S_SQ;
      S_SQ:     state_nxt = S_MAG;
      S_MAG:    if (mag_stat.done) state_nxt = S_OUT;
      S_OUT:    if (out_tready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      func_r   <= in_tuser;
      sample_r <= in_tdata;
    end
    rd_pend_r <= rd_en;
    ptx_r     <= tx_r;
    pty_r     <= ty_r;
    if (state_r == S_DECIDE) begin
      tx_r   <= '0;
      ty_r   <= '0;
      gx_r   <= '0;
      gy_r   <= '0;
      last_r <= (o_cnt_r + 1'b1) == total_r;
    end else begin
      if (rd_en) begin
        if (tx_r == 2'd2) begin
          tx_r <= '0;
          ty_r <= ty_r + 1'b1;
        end else begin
          tx_r <= tx_r + 1'b1;
        end
      end
      if (rd_pend_r) begin
        case (ptx_r)
          2'd0:    gx_r <= gx_r - wx;
          2'd2:    gx_r <= gx_r + wx;
          default: ;
        endcase
        case (pty_r)
          2'd0:    gy_r <= gy_r - wy;
          2'd2:    gy_r <= gy_r + wy;
          default: ;
        endcase
      end
    end
    if (state_r == S_MAG && mag_stat.done) begin
      out_data_r <= mag;
      out_last_r <= last_r;
    end
  end

  // Frame counters.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr_en) begin
      i_cnt_r <= '0;
      i_idx_r <= '0;
      i_row_r <= '0;
      o_cnt_r <= '0;
      o_idx_r <= '0;
      o_c_r   <= '0;
      o_x_r   <= '0;
      o_y_r   <= '0;
    end else if (state_r == S_MAG && mag_stat.done && last_r) begin
      i_cnt_r <= '0;
      i_idx_r <= '0;
      i_row_r <= '0;
      o_cnt_r <= '0;
      o_idx_r <= '0;
      o_c_r   <= '0;
      o_x_r   <= '0;
      o_y_r   <= '0;
    end else begin
      if (wr_en) begin
        i_cnt_r <= i_cnt_r + 1'b1;
        if (((IDX_W+1)'(i_idx_r) + 1'b1) == rowlen_r) begin
          i_idx_r <= '0;
          i_row_r <= i_row_r + 1'b1;
        end else begin
          i_idx_r <= i_idx_r + 1'b1;
        end
      end
      if (state_r == S_MAG && mag_stat.done) begin
        o_cnt_r <= o_cnt_r + 1'b1;
        if (((IDX_W+1)'(o_idx_r) + 1'b1) == rowlen_r) begin
          o_idx_r <= '0;
          o_y_r   <= o_y_r + 1'b1;
        end else begin
          o_idx_r <= o_idx_r + 1'b1;
        end
        if ((o_c_r + 1'b1) == c_eff) begin
          o_c_r <= '0;
          o_x_r <= ((o_x_r + 1'b1) == w_eff) ? '0 : o_x_r + 1'b1;
        end else begin
          o_c_r <= o_c_r + 1'b1;
        end
      end
    end
  end

  sem_line_mem #(
    .ADDR_W(ADDR_W)
  ) u_line_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(sample_r),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  sem_mag u_mag (
    .clk  (clk),
    .rst_n(rst_n),
    .start(state_r == S_SQ),
    .gx   (gx_r),
    .gy   (gy_r),
    .stat (mag_stat),
    .mag  (mag)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Results never run ahead of the samples that produced them.
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    o_cnt_r <= i_cnt_r)
    else $error("result count ahead of sample count");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a result is pending");

  a_mag_done: assert property (@(posedge clk) disable iff (!rst_n)
    mag_stat.done |-> (state_r == S_MAG))
    else $error("magnitude finished outside its state");

  a_mag_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQ) |=> mag_stat.busy)
    else $error("magnitude unit did not start");

endmodule

`default_nettype wire

### design/sem_line_mem.sv
// ----------------------------------------------------------------------------
// Line buffer memory
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_line_mem #(
  parameter int ADDR_W = 14
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [ADDR_W-1:0]          wr_addr,
  input  wire logic [sem_pkg::DATA_W-1:0] wr_data,
  input  wire logic                       rd_en,
  input  wire logic [ADDR_W-1:0]          rd_addr,
  output logic      [sem_pkg::DATA_W-1:0] rd_data
);
  import sem_pkg::*;

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### design/sem_mag.sv
// ----------------------------------------------------------------------------
// Gradient magnitude unit
// Squares and sums the two gradients, then takes a saturated integer root
// one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_mag (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic signed [sem_pkg::GRAD_W-1:0] gx,
  input  wire logic signed [sem_pkg::GRAD_W-1:0] gy,
  output sem_pkg::mag_stat_t                     stat,
  output logic             [sem_pkg::DATA_W-1:0] mag
);
  import sem_pkg::*;

  localparam int AB_W = GRAD_W - 1;

  logic              busy_r, done_r, sum_ph_r;
  logic [AB_W-1:0]   ax, ay, ay_r;
  logic [2*AB_W-1:0] sqx_r;
  logic [SUM_W-1:0]  s_r;
  logic [DATA_W-1:0] res_r, bit_r, trial;
  logic [2*DATA_W-1:0] trial_sq;

  always_comb begin
    ax       = gx[GRAD_W-1] ? AB_W'(-gx) : AB_W'(gx);
    ay       = gy[GRAD_W-1] ? AB_W'(-gy) : AB_W'(gy);
    trial    = res_r | bit_r;
    trial_sq = trial * trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      done_r   <= 1'b0;
      sum_ph_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r   <= 1'b1;
        sum_ph_r <= 1'b1;
        sqx_r    <= ax * ax;
        ay_r     <= ay;
      end else if (busy_r && sum_ph_r) begin
        sum_ph_r <= 1'b0;
        s_r      <= SUM_W'(sqx_r) + SUM_W'(ay_r) * SUM_W'(ay_r);
        res_r    <= '0;
        bit_r    <= {1'b1, {(DATA_W-1){1'b0}}};
      end else if (busy_r) begin
        if (s_r >= SAT_LIMIT) begin
          res_r  <= '1;
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          if (SUM_W'(trial_sq) <= s_r) begin
            res_r <= trial;
          end
          bit_r <= bit_r >> 1;
          if (bit_r[0]) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

  assign stat = '{busy: busy_r, done: done_r};
  assign mag  = res_r;

endmodule

`default_nettype wire
